[sv/hbc_pkg.sv]
// constants and helpers for the hsv to bgr pixel converter
package hbc_pkg;

	localparam int HUE_W = 9;
	localparam int BYTE_W = 8;
	localparam int REM_W = 6;
	localparam int SECT_W = 4;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 24;

	localparam logic [REM_W-1:0] HUE_SECTOR = 6'd60;
	localparam logic [BYTE_W-1:0] FULL_BYTE = 8'd255;
	// 60 * 255
	localparam logic [13:0] HUE_DEN = 14'd15300;

	// floor(hue / 60) = (hue * 1093) >> 16 for every 9-bit hue
	localparam int RECIP60_SHIFT = 16;
	localparam logic [10:0] RECIP60 = 11'd1093;

	// floor(y / 15300) = (y * 4491470) >> 36 for y up to 255 * 15300
	localparam int RECIP_DEN_SHIFT = 36;
	localparam logic [22:0] RECIP_DEN = 23'd4491470;

	typedef enum logic [SECT_W-1:0] {
		SECT_RED_YELLOW   = 4'd0,
		SECT_YELLOW_GREEN = 4'd1,
		SECT_GREEN_CYAN   = 4'd2,
		SECT_CYAN_BLUE    = 4'd3,
		SECT_BLUE_MAGENTA = 4'd4,
		SECT_MAGENTA_RED  = 4'd5
	} sector_t;

	// exact floor(x / 255) for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] y;
		logic [16:0] z;
		y = {1'b0, x} + 17'd1;
		z = y + (y >> 8);
		return z[15:8];
	endfunction

endpackage

[sv/hsv_to_bgr_pixel_convert_top.sv]
// hsv to bgr pixel converter: four-stage pipeline with stream handshakes
// an accepted input request reaches m_axis through the stage 1 to stage 4 registers
// throughput: one pixel per clock; the pipeline advances as a whole when the
// output register is empty or taken, and holds every stage while it is stalled
// reset: arst_n clears all stage valid bits asynchronously, the data path is not reset
module hsv_to_bgr_pixel_convert_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// hue[8:0], saturation[16:9], brightness[24:17], zeros
	input  logic [hbc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// blue[7:0], green[15:8], red[23:16]
	output logic [hbc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	logic advance;
	logic in_fire;

	logic [8:0]  hue;
	logic [7:0]  saturation;
	logic [7:0]  brightness;
	logic [19:0] hue_scaled;
	logic [3:0]  sector;
	logic [8:0]  sect_base;

	// stage 1: sector and remainder
	logic        valid_s1;
	logic [3:0]  sector_s1;
	logic [5:0]  rem_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  val_s1;

	// stage 2: saturation products
	logic        valid_s2;
	logic [3:0]  sector_s2;
	logic [7:0]  val_s2;
	logic [13:0] rem_sat_s2;
	logic [13:0] comp_sat_s2;
	logic [15:0] p_num_s2;

	// stage 3: brightness products and p
	logic        valid_s3;
	logic [3:0]  sector_s3;
	logic [7:0]  val_s3;
	logic [7:0]  p_s3;
	logic [21:0] q_num_s3;
	logic [21:0] t_num_s3;

	// stage 4: output register
	logic        valid_s4;
	logic [7:0]  blue_s4;
	logic [7:0]  green_s4;
	logic [7:0]  red_s4;

	logic [44:0] q_prod;
	logic [44:0] t_prod;
	logic [7:0]  q_val;
	logic [7:0]  t_val;
	logic [7:0]  blue_nx;
	logic [7:0]  green_nx;
	logic [7:0]  red_nx;

	assign advance = !valid_s4 || m_axis_tready;
	assign s_axis_tready = advance;
	assign in_fire = s_axis_tvalid && advance;

	assign hue = s_axis_tdata[8:0];
	assign saturation = s_axis_tdata[16:9];
	assign brightness = s_axis_tdata[24:17];

	assign hue_scaled = 20'(hue) * 20'(hbc_pkg::RECIP60);
	assign sector = hue_scaled[hbc_pkg::RECIP60_SHIFT +: hbc_pkg::SECT_W];
	assign sect_base = 9'(sector) * 9'(hbc_pkg::HUE_SECTOR);

	assign q_prod = 45'(q_num_s3) * 45'(hbc_pkg::RECIP_DEN);
	assign t_prod = 45'(t_num_s3) * 45'(hbc_pkg::RECIP_DEN);
	assign q_val = q_prod[hbc_pkg::RECIP_DEN_SHIFT +: 8];
	assign t_val = t_prod[hbc_pkg::RECIP_DEN_SHIFT +: 8];

	always_comb begin
		blue_nx = '0;
		green_nx = '0;
		red_nx = '0;
		case (sector_s3)
			hbc_pkg::SECT_RED_YELLOW: begin
				blue_nx = p_s3;
				green_nx = t_val;
				red_nx = val_s3;
			end
			hbc_pkg::SECT_YELLOW_GREEN: begin
				blue_nx = p_s3;
				green_nx = val_s3;
				red_nx = q_val;
			end
			hbc_pkg::SECT_GREEN_CYAN: begin
				blue_nx = t_val;
				green_nx = val_s3;
				red_nx = p_s3;
			end
			hbc_pkg::SECT_CYAN_BLUE: begin
				blue_nx = val_s3;
				green_nx = q_val;
				red_nx = p_s3;
			end
			hbc_pkg::SECT_BLUE_MAGENTA: begin
				blue_nx = val_s3;
				green_nx = p_s3;
				red_nx = t_val;
			end
			hbc_pkg::SECT_MAGENTA_RED: begin
				blue_nx = q_val;
				green_nx = p_s3;
				red_nx = val_s3;
			end
			// hue of 360 and above gives black
			default: begin
				blue_nx = '0;
				green_nx = '0;
				red_nx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_fire;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sector_s1 <= sector;
			rem_s1 <= 6'(hue - sect_base);
			sat_s1 <= saturation;
			val_s1 <= brightness;

			sector_s2 <= sector_s1;
			val_s2 <= val_s1;
			rem_sat_s2 <= 14'(rem_s1) * 14'(sat_s1);
			comp_sat_s2 <= 14'(hbc_pkg::HUE_SECTOR - rem_s1) * 14'(sat_s1);
			p_num_s2 <= 16'(val_s1) * 16'(hbc_pkg::FULL_BYTE - sat_s1);

			sector_s3 <= sector_s2;
			val_s3 <= val_s2;
			p_s3 <= hbc_pkg::div255(p_num_s2);
			q_num_s3 <= 22'(val_s2) * 22'(hbc_pkg::HUE_DEN - rem_sat_s2);
			t_num_s3 <= 22'(val_s2) * 22'(hbc_pkg::HUE_DEN - comp_sat_s2);

			blue_s4 <= blue_nx;
			green_s4 <= green_nx;
			red_s4 <= red_nx;
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata = {red_s4, green_s4, blue_s4};

`ifndef ASSERT_OFF
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("accepted request did not enter stage 1");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable({valid_s1, valid_s2, valid_s3, valid_s4}))
		else $error("pipeline valid bits moved during a stall");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && advance |=> m_axis_tvalid)
		else $error("stage 3 request lost on the way to the output");

	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> rem_s1 < hbc_pkg::HUE_SECTOR)
		else $error("hue remainder out of range");
`endif

endmodule

[dv/hsv_to_bgr_pixel_convert_top_test.sv]
// testbench for the hsv to bgr pixel converter: directed and random pixels, scoreboard check
module hsv_to_bgr_pixel_convert_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [6:0]                 fill;
		logic [hbc_pkg::BYTE_W-1:0] brightness;
		logic [hbc_pkg::BYTE_W-1:0] saturation;
		logic [hbc_pkg::HUE_W-1:0]  hue;
	} hsv_req_t;

	typedef struct packed {
		logic [hbc_pkg::BYTE_W-1:0] red;
		logic [hbc_pkg::BYTE_W-1:0] green;
		logic [hbc_pkg::BYTE_W-1:0] blue;
	} bgr_res_t;

	class pixel_scoreboard;
		bgr_res_t expected_bgr[$];
		int n_noted;
		int n_checked;
		int n_errors;
		int n_black;

		function bgr_res_t convert_hsv(hsv_req_t px);
			int unsigned v;
			int unsigned s;
			int unsigned rem;
			int unsigned den;
			int unsigned p;
			int unsigned q;
			int unsigned t;
			hbc_pkg::sector_t sect;
			bgr_res_t res;
			v = px.brightness;
			s = px.saturation;
			den = hbc_pkg::HUE_DEN;
			rem = px.hue % hbc_pkg::HUE_SECTOR;
			sect = hbc_pkg::sector_t'(px.hue / hbc_pkg::HUE_SECTOR);
			p = v * (hbc_pkg::FULL_BYTE - s) / hbc_pkg::FULL_BYTE;
			q = v * (den - rem * s) / den;
			t = v * (den - (hbc_pkg::HUE_SECTOR - rem) * s) / den;
			res = '0;
			case (sect)
			hbc_pkg::SECT_RED_YELLOW: begin
				res.blue = 8'(p); res.green = 8'(t); res.red = 8'(v);
			end
			hbc_pkg::SECT_YELLOW_GREEN: begin
				res.blue = 8'(p); res.green = 8'(v); res.red = 8'(q);
			end
			hbc_pkg::SECT_GREEN_CYAN: begin
				res.blue = 8'(t); res.green = 8'(v); res.red = 8'(p);
			end
			hbc_pkg::SECT_CYAN_BLUE: begin
				res.blue = 8'(v); res.green = 8'(q); res.red = 8'(p);
			end
			hbc_pkg::SECT_BLUE_MAGENTA: begin
				res.blue = 8'(v); res.green = 8'(p); res.red = 8'(t);
			end
			hbc_pkg::SECT_MAGENTA_RED: begin
				res.blue = 8'(q); res.green = 8'(p); res.red = 8'(v);
			end
			// hue of 360 and up has no sector: black
			default: res = '0;
			endcase
			return res;
		endfunction

		function void note_pixel(hsv_req_t px);
			expected_bgr.push_back(convert_hsv(px));
			n_noted++;
			if (px.hue >= 9'd360)
				n_black++;
		endfunction

		function void report(string field, logic [7:0] want, logic [7:0] got);
			n_errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		endfunction

		function void check_pixel(bgr_res_t got);
			bgr_res_t want;
			if (expected_bgr.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected pixel, expected none, got %h", $time, got);
				return;
			end
			want = expected_bgr.pop_front();
			n_checked++;
			if (got.blue !== want.blue)
				report("blue", want.blue, got.blue);
			if (got.green !== want.green)
				report("green", want.green, got.green);
			if (got.red !== want.red)
				report("red", want.red, got.red);
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [hbc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [hbc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	pixel_scoreboard sb = new();

	hsv_to_bgr_pixel_convert_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("timeout with %0d pixels still expected", sb.expected_bgr.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// entered and left at a rising edge; request accepted at the edge it returns on
	task automatic send_pixel(input hsv_req_t px, input bit steady);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		sb.note_pixel(px);
	endtask

	function automatic logic [7:0] random_byte();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 8'd0;
		else if (pick == 1)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic hsv_req_t random_pixel();
		hsv_req_t px;
		int pick;
		px = '0;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			px.hue = 9'($urandom_range(360, 511));
		else if (pick <= 2)
			// sector boundaries, either side
			px.hue = 9'($urandom_range(0, 5) * 60 + ($urandom_range(0, 1) ? 59 : 0));
		else
			px.hue = 9'($urandom_range(0, 359));
		px.saturation = random_byte();
		px.brightness = random_byte();
		return px;
	endfunction

	initial begin
		int unsigned boundary_hues[14];
		hsv_req_t px;
		int i;
		boundary_hues = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359, 360, 511};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every sector edge at full saturation and brightness, then out of range
		for (i = 0; i < 14; i++) begin
			px = '0;
			px.hue = 9'(boundary_hues[i]);
			px.saturation = 8'd255;
			px.brightness = 8'd255;
			send_pixel(px, 1'b0);
		end
		px = '0; px.hue = 9'd30;  px.saturation = 8'd0;   px.brightness = 8'd255;
		send_pixel(px, 1'b0);
		px = '0; px.hue = 9'd90;  px.saturation = 8'd255; px.brightness = 8'd0;
		send_pixel(px, 1'b0);
		px = '0; px.hue = 9'd210; px.saturation = 8'd128; px.brightness = 8'd200;
		send_pixel(px, 1'b0);
		px = '0; px.hue = 9'd330; px.saturation = 8'd1;   px.brightness = 8'd254;
		send_pixel(px, 1'b0);
		px = '0; px.hue = 9'd270; px.saturation = 8'd200; px.brightness = 8'd255;
		send_pixel(px, 1'b0);
		px = '0; px.hue = 9'd15;  px.saturation = 8'd255; px.brightness = 8'd1;
		send_pixel(px, 1'b0);

		// sender holds off until the pipeline has drained
		s_axis_tvalid <= 1'b0;
		while (sb.expected_bgr.size() != 0) @(posedge clk);

		for (i = 0; i < 700; i++)
			send_pixel(random_pixel(), i >= 400 && i < 480);
		s_axis_tvalid <= 1'b0;

		while (sb.expected_bgr.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d pixels (%0d with hue out of range), checked %0d results",
			sb.n_noted, sb.n_black, sb.n_checked);
		$display("covered all six sectors with edges, back-pressure stalls and idle gaps");
		if (sb.n_errors == 0 && sb.expected_bgr.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int gap;
		bgr_res_t got;
		bit held;
		held = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && sb.n_checked >= 150) begin
				// long stall so the pipeline fills and blocks its input
				gap = 60;
				held = 1'b1;
			end else if (sb.n_checked >= 250 && sb.n_checked < 330) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 8);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(negedge clk); while (!m_axis_tvalid);
			got = m_axis_tdata;
			@(posedge clk);
			sb.check_pixel(got);
		end
	end

endmodule

[hsv_to_bgr_pixel_convert_top.f]
sv/hbc_pkg.sv
sv/hsv_to_bgr_pixel_convert_top.sv
dv/hsv_to_bgr_pixel_convert_top_test.sv
